// File: design/obf_pkg.sv
// obf_pkg: shared types, codes and weight tables for the outline bezier flattener
// no dependencies

package obf_pkg;

  localparam int SCALE_W      = 25;
  localparam int SCALE_FRAC   = 24;
  localparam int WEIGHT_SHIFT = 6;
  localparam int VERT_W       = 32;
  localparam int KIND_W       = 3;
  localparam int WGT_W        = 7;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 25'd8192;

  typedef enum logic [KIND_W-1:0] {
    KIND_MOVE   = 3'd0,
    KIND_LINE   = 3'd1,
    KIND_QUAD   = 3'd2,
    KIND_CUBIC  = 3'd3,
    KIND_FINISH = 3'd4
  } kind_t;

  typedef logic [1:0] step_t;
  localparam step_t STEP_END = 2'd3;

  typedef logic [WGT_W-1:0] wgt_t;

  // weights on pen, ctrl1, ctrl2, target; they sum to 64, or to 0 for finish
  typedef struct packed {
    wgt_t w_pen;
    wgt_t w_c1;
    wgt_t w_c2;
    wgt_t w_to;
  } wgt_set_t;

  typedef struct packed {
    logic starts_contour;
    logic outline_done;
    logic last;
  } vtag_t;

  typedef struct packed {
    logic [VERT_W-1:0] vert_x;
    logic [VERT_W-1:0] vert_y;
    vtag_t             tag;
  } vert_t;

  function automatic wgt_set_t step_weights(kind_t kind, step_t step);
    wgt_set_t w;
    w = '{w_pen: 7'd0, w_c1: 7'd0, w_c2: 7'd0, w_to: 7'd0};
    unique case (kind)
      KIND_MOVE, KIND_LINE: begin
        w = '{w_pen: 7'd0, w_c1: 7'd0, w_c2: 7'd0, w_to: 7'd64};
      end
      KIND_QUAD: begin
        unique case (step)
          2'd0: w = '{w_pen: 7'd36, w_c1: 7'd24, w_c2: 7'd0, w_to: 7'd4};
          2'd1: w = '{w_pen: 7'd16, w_c1: 7'd32, w_c2: 7'd0, w_to: 7'd16};
          2'd2: w = '{w_pen: 7'd4,  w_c1: 7'd24, w_c2: 7'd0, w_to: 7'd36};
          default: w = '{w_pen: 7'd0, w_c1: 7'd0, w_c2: 7'd0, w_to: 7'd64};
        endcase
      end
      KIND_CUBIC: begin
        unique case (step)
          2'd0: w = '{w_pen: 7'd27, w_c1: 7'd27, w_c2: 7'd9,  w_to: 7'd1};
          2'd1: w = '{w_pen: 7'd8,  w_c1: 7'd24, w_c2: 7'd24, w_to: 7'd8};
          2'd2: w = '{w_pen: 7'd1,  w_c1: 7'd9,  w_c2: 7'd27, w_to: 7'd27};
          default: w = '{w_pen: 7'd0, w_c1: 7'd0, w_c2: 7'd0, w_to: 7'd64};
        endcase
      end
      default: begin
        w = '{w_pen: 7'd0, w_c1: 7'd0, w_c2: 7'd0, w_to: 7'd0};
      end
    endcase
    return w;
  endfunction

endpackage

// File: design/obf_fifo.sv
// obf_fifo: small synchronous queue with head visible while not empty
// depends on nothing; used for the command queue and the vertex queue

module obf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH):0]     count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH) + 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: design/obf_front.sv
// obf_front: accepts outline commands, drops unused codes, tracks the pen
// depends on obf_pkg; feeds the command queue

module obf_front
  import obf_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  input  logic [KIND_W-1:0]            in_kind,
  input  logic signed [COORD_BITS-1:0] in_ctrl1_x,
  input  logic signed [COORD_BITS-1:0] in_ctrl1_y,
  input  logic signed [COORD_BITS-1:0] in_ctrl2_x,
  input  logic signed [COORD_BITS-1:0] in_ctrl2_y,
  input  logic signed [COORD_BITS-1:0] in_to_x,
  input  logic signed [COORD_BITS-1:0] in_to_y,
  input  logic                         q_full,
  output logic                         q_push,
  output logic [KIND_W+8*COORD_BITS-1:0] q_data
);

  logic signed [COORD_BITS-1:0] pen_x_r, pen_x_nxt;
  logic signed [COORD_BITS-1:0] pen_y_r, pen_y_nxt;
  logic                         accept;
  logic                         kind_ok;
  kind_t                        kind;

  assign accept = in_push && !q_full;
  assign kind   = kind_t'(in_kind);

  always_comb begin
    kind_ok   = 1'b0;
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    unique case (kind)
      KIND_MOVE, KIND_LINE, KIND_QUAD, KIND_CUBIC: begin
        kind_ok   = 1'b1;
        pen_x_nxt = in_to_x;
        pen_y_nxt = in_to_y;
      end
      KIND_FINISH: begin
        kind_ok   = 1'b1;
        pen_x_nxt = '0;
        pen_y_nxt = '0;
      end
      default: begin
        kind_ok = 1'b0;
      end
    endcase
  end

  assign q_push = accept && kind_ok;
  assign q_data = {in_kind, pen_x_r, pen_y_r, in_ctrl1_x, in_ctrl1_y,
                   in_ctrl2_x, in_ctrl2_y, in_to_x, in_to_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
    end else if (accept && kind_ok) begin
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
    end
  end

endmodule

// File: design/obf_back.sv
// obf_back: steps through each queued command, weights, scales and saturates vertices
// depends on obf_pkg; writes into the vertex queue with credit on its fill level

module obf_back
  import obf_pkg::*;
#(
  parameter int COORD_BITS    = 16,
  parameter int OUT_FRAC_BITS = 16,
  parameter int OUT_DEPTH     = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cmd_empty,
  input  logic [KIND_W+8*COORD_BITS-1:0] cmd_data,
  output logic                           cmd_pop,
  input  logic [SCALE_W-1:0]             scale,
  input  logic [$clog2(OUT_DEPTH):0]     out_count,
  output logic                           out_push,
  output vert_t                          out_data
);

  localparam int CB    = COORD_BITS;
  localparam int WS    = COORD_BITS + 8;
  localparam int PW    = WS + SCALE_W + 1;
  localparam int SH    = SCALE_FRAC + WEIGHT_SHIFT - OUT_FRAC_BITS;
  localparam int CNT_W = $clog2(OUT_DEPTH) + 2;

  localparam logic signed [PW-1:0] VMAX = {{(PW-VERT_W+1){1'b0}}, {(VERT_W-1){1'b1}}};
  localparam logic signed [PW-1:0] VMIN = {{(PW-VERT_W+1){1'b1}}, {(VERT_W-1){1'b0}}};

  logic                busy_r, busy_nxt;
  step_t               step_r, step_nxt;
  kind_t               kind_r;
  logic [8*CB-1:0]     pts_r;

  logic                s1_v_r;
  logic signed [WS-1:0] s1_x_r, s1_y_r;
  vtag_t               s1_tag_r;
  logic                s2_v_r;
  logic signed [PW-1:0] s2_x_r, s2_y_r;
  vtag_t               s2_tag_r;

  logic signed [CB-1:0] p0x, p0y, c1x, c1y, c2x, c2y, tx, ty;
  logic [CNT_W-1:0]    pending;
  logic                room, issue, last_step, done_item;
  wgt_set_t            wgt;
  logic signed [WS-1:0] wx, wy;
  vtag_t               tag;
  logic signed [PW-1:0] sh_x, sh_y;

  function automatic logic [VERT_W-1:0] sat32(logic signed [PW-1:0] v);
    logic [VERT_W-1:0] r;
    if (v > VMAX) begin
      r = {1'b0, {(VERT_W-1){1'b1}}};
    end else if (v < VMIN) begin
      r = {1'b1, {(VERT_W-1){1'b0}}};
    end else begin
      r = v[VERT_W-1:0];
    end
    return r;
  endfunction

  assign p0x = $signed(pts_r[8*CB-1 -: CB]);
  assign p0y = $signed(pts_r[7*CB-1 -: CB]);
  assign c1x = $signed(pts_r[6*CB-1 -: CB]);
  assign c1y = $signed(pts_r[5*CB-1 -: CB]);
  assign c2x = $signed(pts_r[4*CB-1 -: CB]);
  assign c2y = $signed(pts_r[3*CB-1 -: CB]);
  assign tx  = $signed(pts_r[2*CB-1 -: CB]);
  assign ty  = $signed(pts_r[CB-1 -: CB]);

  // credit: queued vertices plus those still in the two stages
  assign pending = CNT_W'(out_count) + CNT_W'(s1_v_r) + CNT_W'(s2_v_r);
  assign room    = (pending < CNT_W'(OUT_DEPTH));
  assign issue   = busy_r && room;

  assign last_step = ((kind_r == KIND_QUAD) || (kind_r == KIND_CUBIC)) ?
                     (step_r == STEP_END) : 1'b1;
  assign done_item = issue && last_step;
  assign cmd_pop   = !cmd_empty && (!busy_r || done_item);

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (cmd_pop) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (done_item) begin
      busy_nxt = 1'b0;
    end else if (issue) begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_comb begin
    wgt = step_weights(kind_r, step_r);
    wx  = WS'($signed({1'b0, wgt.w_pen})) * WS'(p0x)
        + WS'($signed({1'b0, wgt.w_c1}))  * WS'(c1x)
        + WS'($signed({1'b0, wgt.w_c2}))  * WS'(c2x)
        + WS'($signed({1'b0, wgt.w_to}))  * WS'(tx);
    wy  = WS'($signed({1'b0, wgt.w_pen})) * WS'(p0y)
        + WS'($signed({1'b0, wgt.w_c1}))  * WS'(c1y)
        + WS'($signed({1'b0, wgt.w_c2}))  * WS'(c2y)
        + WS'($signed({1'b0, wgt.w_to}))  * WS'(ty);
    tag.starts_contour = (kind_r == KIND_MOVE);
    tag.outline_done   = (kind_r == KIND_FINISH);
    tag.last           = last_step;
  end

  // floor shift to the output fraction, then clamp to 32 bits
  assign sh_x = s2_x_r >>> SH;
  assign sh_y = s2_y_r >>> SH;

  assign out_push = s2_v_r;
  always_comb begin
    out_data.vert_x = sat32(sh_x);
    out_data.vert_y = sat32(sh_y);
    out_data.tag    = s2_tag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      kind_r <= kind_t'(cmd_data[KIND_W+8*CB-1 -: KIND_W]);
      pts_r  <= cmd_data[8*CB-1:0];
    end
    s1_x_r   <= wx;
    s1_y_r   <= wy;
    s1_tag_r <= tag;
    s2_x_r   <= PW'(s1_x_r) * PW'($signed({1'b0, scale}));
    s2_y_r   <= PW'(s1_y_r) * PW'($signed({1'b0, scale}));
    s2_tag_r <= s1_tag_r;
  end

endmodule

// File: design/outline_bezier_flattener.sv
// first vertex path: command queue, back end command register, s1, s2, vertex queue
// vertices: quadratic and cubic emit four each, the rest one; the back end's single
//   weighting and scaling pipe emits one vertex per cycle while the vertex queue has room
// reset: synchronous rst_n clears the pen to (0,0), scale to 8192 and empties both queues
// top level; depends on obf_pkg, obf_front, obf_fifo, obf_back

module outline_bezier_flattener
  import obf_pkg::*;
#(
  parameter int COORD_BITS    = 16,
  parameter int OUT_FRAC_BITS = 16,
  parameter int CMD_DEPTH     = 2,
  parameter int OUT_DEPTH     = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [KIND_W-1:0]            in_kind,
  input  logic signed [COORD_BITS-1:0] in_ctrl1_x,
  input  logic signed [COORD_BITS-1:0] in_ctrl1_y,
  input  logic signed [COORD_BITS-1:0] in_ctrl2_x,
  input  logic signed [COORD_BITS-1:0] in_ctrl2_y,
  input  logic signed [COORD_BITS-1:0] in_to_x,
  input  logic signed [COORD_BITS-1:0] in_to_y,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic signed [VERT_W-1:0]     out_vert_x,
  output logic signed [VERT_W-1:0]     out_vert_y,
  output logic                         out_starts_contour,
  output logic                         out_outline_done,
  output logic                         out_last,
  input  logic                         cfg_wr_en,
  input  logic [SCALE_W-1:0]           cfg_wr_data
);

  localparam int CMD_W = KIND_W + 8 * COORD_BITS;
  localparam int VW    = $bits(vert_t);

  logic [SCALE_W-1:0]           scale_r;
  logic                         cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic [CMD_W-1:0]             cmd_wdata, cmd_rdata;
  logic [$clog2(CMD_DEPTH):0]   cmd_count;
  logic                         vq_push, vq_full;
  logic [$clog2(OUT_DEPTH):0]   vq_count;
  vert_t                        vq_wdata, vq_rdata;
  logic [VW-1:0]                vq_rbits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_wr_en) begin
      scale_r <= cfg_wr_data;
    end
  end

  assign in_full = cmd_full;

  obf_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_kind    (in_kind),
    .in_ctrl1_x (in_ctrl1_x),
    .in_ctrl1_y (in_ctrl1_y),
    .in_ctrl2_x (in_ctrl2_x),
    .in_ctrl2_y (in_ctrl2_y),
    .in_to_x    (in_to_x),
    .in_to_y    (in_to_y),
    .q_full     (cmd_full),
    .q_push     (cmd_push),
    .q_data     (cmd_wdata)
  );

  obf_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (cmd_wdata),
    .pop     (cmd_pop),
    .rd_data (cmd_rdata),
    .full    (cmd_full),
    .empty   (cmd_empty),
    .count   (cmd_count)
  );

  obf_back #(
    .COORD_BITS    (COORD_BITS),
    .OUT_FRAC_BITS (OUT_FRAC_BITS),
    .OUT_DEPTH     (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_rdata),
    .cmd_pop   (cmd_pop),
    .scale     (scale_r),
    .out_count (vq_count),
    .out_push  (vq_push),
    .out_data  (vq_wdata)
  );

  obf_fifo #(
    .WIDTH (VW),
    .DEPTH (OUT_DEPTH)
  ) u_vert_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (vq_push),
    .wr_data (vq_wdata),
    .pop     (out_pop),
    .rd_data (vq_rbits),
    .full    (vq_full),
    .empty   (out_empty),
    .count   (vq_count)
  );

  assign vq_rdata           = vert_t'(vq_rbits);
  assign out_vert_x         = $signed(vq_rdata.vert_x);
  assign out_vert_y         = $signed(vq_rdata.vert_y);
  assign out_starts_contour = vq_rdata.tag.starts_contour;
  assign out_outline_done   = vq_rdata.tag.outline_done;
  assign out_last           = vq_rdata.tag.last;

  // credit must keep the vertex queue from overflowing
  a_vq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    vq_push |-> !vq_full)
    else $error("vertex queue written while full");

  a_cmd_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command queue popped while empty");

  a_cmd_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> (cmd_count < ($clog2(CMD_DEPTH) + 1)'(CMD_DEPTH)))
    else $error("command pushed with no space");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_outline_done) |-> (out_vert_x == '0 && out_vert_y == '0
      && out_last && !out_starts_contour))
    else $error("finish marker carries a vertex");

endmodule
